>>> sv/dttf_pkg.sv
// dttf_pkg: shared types and constants for the decimal text to fixed-point converter
`default_nettype none
package dttf_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 34;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [INDEX_W-1:0] POS_MAX = 4'd15;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_EMPTY    = 3'd1,
        STATUS_NO_INT   = 3'd2,
        STATUS_INT_OVF  = 3'd3,
        STATUS_FRAC_OVF = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT,
        ST_FRAC,
        ST_DONE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    set_neg;
        logic    int_acc;
        logic    frac_acc;
        logic    pos_adv;
        logic    finish_ok;
        logic    last_minus_two;
        logic    finish_err;
        status_t err_code;
        logic    load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic is_digit;
        logic is_nul;
        logic is_minus;
        logic is_plus;
        logic int_none;
        logic int_full;
        logic frac_none;
        logic frac_full;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> sv/dttf_if.sv
// dttf_if: valid/ready channel interfaces for characters and results
`default_nettype none
interface dttf_char_if;
    logic                          valid;
    logic                          ready;
    logic [dttf_pkg::CHAR_W-1:0]   char_code;
    logic                          start_of_text;

    modport source (output valid, output char_code, output start_of_text, input ready);
    modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

interface dttf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dttf_pkg::VALUE_W-1:0]  value;
    logic [dttf_pkg::INDEX_W-1:0]         last_index;
    logic [dttf_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output value, output last_index, output status, input ready);
    modport sink   (input valid, input value, input last_index, input status, output ready);
endinterface
`default_nettype wire

>>> sv/dttf_frac_div.sv
// dttf_frac_div: restoring divider giving the fraction bits, one quotient bit per cycle
`default_nettype none
module dttf_frac_div #(
    parameter int DIVIDEND_W = 14,
    parameter int DIVISOR_W  = 14,
    parameter int QUOT_W     = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [QUOT_W-1:0]     quotient,
    output logic                       done
);
    localparam int CW = $clog2(QUOT_W);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;

    logic [DIVISOR_W:0]   rem_dbl;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;

    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        rem_diff = rem_dbl - {1'b0, divisor};
        fits     = rem_dbl >= {1'b0, divisor};
    end

    assign done     = busy_reg && (cnt_reg == CW'(QUOT_W - 1));
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder stays below the divisor, so the fraction is numerator/divisor < 1
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIVISOR_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_diff[DIVISOR_W-1:0] : rem_dbl[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end
endmodule
`default_nettype wire

>>> sv/dttf_datapath.sv
// dttf_datapath: digit accumulators, position counter, divider and result register
`default_nettype none
module dttf_datapath #(
    parameter int INT_DIGITS  = 5,
    parameter int FRAC_DIGITS = 4,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dttf_pkg::CHAR_W-1:0] char_code,
    input  wire logic                        start_of_text,
    input  wire dttf_pkg::cmd_t              cmd,
    output dttf_pkg::stat_t                  stat,
    dttf_result_if.source                    result
);
    localparam int IAW = $clog2(10 ** INT_DIGITS);
    localparam int ICW = $clog2(INT_DIGITS + 1);
    localparam int FAW = $clog2(10 ** FRAC_DIGITS);
    localparam int FCW = $clog2(FRAC_DIGITS + 1);
    localparam int SW  = $clog2(10 ** FRAC_DIGITS + 1);
    localparam int VW  = dttf_pkg::VALUE_W;
    localparam int XW  = dttf_pkg::INDEX_W;

    logic                   neg_reg;
    logic [IAW-1:0]         int_acc_reg;
    logic [ICW-1:0]         int_cnt_reg;
    logic [FAW-1:0]         frac_acc_reg;
    logic [FCW-1:0]         frac_cnt_reg;
    logic [SW-1:0]          scale_reg;
    logic [XW-1:0]          pos_reg;
    logic [XW-1:0]          last_hold_reg;
    logic                   err_hold_reg;
    dttf_pkg::status_t      code_hold_reg;

    logic                   out_valid_reg;
    logic signed [VW-1:0]   value_reg;
    logic [XW-1:0]          last_reg;
    logic [dttf_pkg::STATUS_W-1:0] status_reg;

    logic [dttf_pkg::CHAR_W-1:0] digit_off;
    logic [3:0]             digit;
    logic [IAW-1:0]         int_base;
    logic [IAW+3:0]         int_wide;
    logic [FAW+3:0]         frac_wide;
    logic [SW+3:0]          scale_wide;
    logic [XW-1:0]          pos_cur;
    logic [XW-1:0]          pos_next;
    logic [FRAC_BITS-1:0]   quotient;
    logic                   div_done;
    logic [VW+IAW+FRAC_BITS-1:0] mag_wide;
    logic [VW-1:0]          mag;
    logic [VW-1:0]          signed_mag;

    always_comb
    begin
        digit_off  = char_code - dttf_pkg::CHAR_ZERO;
        digit      = digit_off[3:0];
        int_base   = cmd.clear ? '0 : int_acc_reg;
        int_wide   = ({4'b0, int_base} << 3) + ({4'b0, int_base} << 1) + (IAW + 4)'(digit);
        frac_wide  = ({4'b0, frac_acc_reg} << 3) + ({4'b0, frac_acc_reg} << 1)
                   + (FAW + 4)'(digit);
        scale_wide = ({4'b0, scale_reg} << 3) + ({4'b0, scale_reg} << 1);
        pos_cur    = cmd.clear ? '0 : pos_reg;
        pos_next   = (pos_cur == dttf_pkg::POS_MAX) ? pos_cur : pos_cur + 1'b1;
        // integer part sits above the fraction bits, wrapped to the output width
        mag_wide   = {VW'(0), int_acc_reg, quotient};
        mag        = mag_wide[VW-1:0];
        signed_mag = neg_reg ? (~mag + 1'b1) : mag;
    end

    always_comb
    begin
        stat.start     = start_of_text;
        stat.is_digit  = (char_code >= dttf_pkg::CHAR_ZERO) && (char_code <= dttf_pkg::CHAR_NINE);
        stat.is_nul    = char_code == dttf_pkg::CHAR_NUL;
        stat.is_minus  = char_code == dttf_pkg::CHAR_MINUS;
        stat.is_plus   = char_code == dttf_pkg::CHAR_PLUS;
        stat.int_none  = int_cnt_reg == '0;
        stat.int_full  = int_cnt_reg == ICW'(INT_DIGITS);
        stat.frac_none = frac_cnt_reg == '0;
        stat.frac_full = frac_cnt_reg == FCW'(FRAC_DIGITS);
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || result.ready;
    end

    dttf_frac_div #(
        .DIVIDEND_W (FAW),
        .DIVISOR_W  (SW),
        .QUOT_W     (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.finish_ok),
        .dividend (frac_acc_reg),
        .divisor  (scale_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_cnt_reg   <= '0;
            frac_cnt_reg  <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                int_cnt_reg <= cmd.int_acc ? ICW'(1) : '0;
            end
            else if (cmd.int_acc)
            begin
                int_cnt_reg <= int_cnt_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                frac_cnt_reg <= '0;
            end
            else if (cmd.frac_acc)
            begin
                frac_cnt_reg <= frac_cnt_reg + 1'b1;
            end
            if (cmd.pos_adv)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            neg_reg      <= cmd.set_neg;
            frac_acc_reg <= '0;
            scale_reg    <= SW'(1);
        end
        else if (cmd.frac_acc)
        begin
            frac_acc_reg <= frac_wide[FAW-1:0];
            scale_reg    <= scale_wide[SW-1:0];
        end
        if (cmd.clear || cmd.int_acc)
        begin
            int_acc_reg <= cmd.int_acc ? int_wide[IAW-1:0] : '0;
        end
        if (cmd.finish_ok)
        begin
            last_hold_reg <= pos_cur - (cmd.last_minus_two ? XW'(2) : XW'(1));
            err_hold_reg  <= 1'b0;
            code_hold_reg <= dttf_pkg::STATUS_OK;
        end
        else if (cmd.finish_err)
        begin
            last_hold_reg <= '0;
            err_hold_reg  <= 1'b1;
            code_hold_reg <= cmd.err_code;
        end
        if (cmd.load_out)
        begin
            value_reg  <= err_hold_reg ? '0 : signed_mag;
            last_reg   <= last_hold_reg;
            status_reg <= code_hold_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.value      = value_reg;
    assign result.last_index = last_reg;
    assign result.status     = status_reg;
endmodule
`default_nettype wire

>>> sv/dttf_controller.sv
// dttf_controller: parse state machine driving the datapath
`default_nettype none
module dttf_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dttf_pkg::stat_t stat,
    output dttf_pkg::cmd_t       cmd,
    output dttf_pkg::state_t     state
);
    dttf_pkg::state_t state_reg;
    dttf_pkg::state_t state_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dttf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            dttf_pkg::ST_IDLE, dttf_pkg::ST_INT, dttf_pkg::ST_FRAC, dttf_pkg::ST_DONE:
            begin
                in_ready = 1'b1;
            end
            dttf_pkg::ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = dttf_pkg::ST_EMIT;
                end
            end
            dttf_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dttf_pkg::ST_DONE;
                end
            end
            default:
            begin
                state_next = dttf_pkg::ST_IDLE;
            end
        endcase

        accept = in_valid && in_ready;

        if (accept && stat.start)
        begin
            cmd.clear   = 1'b1;
            cmd.pos_adv = 1'b1;
            state_next  = dttf_pkg::ST_INT;
            if (stat.is_nul)
            begin
                cmd.finish_err = 1'b1;
                cmd.err_code   = dttf_pkg::STATUS_EMPTY;
                state_next     = dttf_pkg::ST_EMIT;
            end
            else if (stat.is_minus)
            begin
                cmd.set_neg = 1'b1;
            end
            else if (stat.is_digit)
            begin
                cmd.int_acc = 1'b1;
            end
            else if (!stat.is_plus)
            begin
                cmd.finish_err = 1'b1;
                cmd.err_code   = dttf_pkg::STATUS_NO_INT;
                state_next     = dttf_pkg::ST_EMIT;
            end
        end
        else if (accept && state_reg == dttf_pkg::ST_INT)
        begin
            cmd.pos_adv = 1'b1;
            if (stat.is_digit)
            begin
                if (stat.int_full)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code   = dttf_pkg::STATUS_INT_OVF;
                    state_next     = dttf_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.int_acc = 1'b1;
                end
            end
            else if (stat.int_none)
            begin
                cmd.finish_err = 1'b1;
                cmd.err_code   = dttf_pkg::STATUS_NO_INT;
                state_next     = dttf_pkg::ST_EMIT;
            end
            else if (stat.is_nul)
            begin
                cmd.finish_ok = 1'b1;
                state_next    = dttf_pkg::ST_DIVIDE;
            end
            else
            begin
                // single separator skipped
                state_next = dttf_pkg::ST_FRAC;
            end
        end
        else if (accept && state_reg == dttf_pkg::ST_FRAC)
        begin
            cmd.pos_adv = 1'b1;
            if (stat.is_digit)
            begin
                if (stat.frac_full)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code   = dttf_pkg::STATUS_FRAC_OVF;
                    state_next     = dttf_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.frac_acc = 1'b1;
                end
            end
            else
            begin
                // ending character: with no fraction digits, the last digit sits before the separator
                cmd.finish_ok      = 1'b1;
                cmd.last_minus_two = stat.frac_none;
                state_next         = dttf_pkg::ST_DIVIDE;
            end
        end
    end

    assign state = state_reg;
endmodule
`default_nettype wire

>>> sv/decimal_text_to_fixed_point.sv
// decimal_text_to_fixed_point: top level joining parse controller and datapath
// characters that end no number stream one per cycle
// an ok result turns valid after the ending character is taken, the one-bit-per-cycle
// fraction divider finishes and the result is loaded; an error result skips the divider
// input is held off during division and while a finished result waits on a full output
// asynchronous active-low reset returns to idle with no result pending
`default_nettype none
module decimal_text_to_fixed_point #(
    parameter int INT_DIGITS  = 5,
    parameter int FRAC_DIGITS = 4,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dttf_char_if.sink     chars,
    dttf_result_if.source result
);
    dttf_pkg::cmd_t   cmd;
    dttf_pkg::stat_t  stat;
    dttf_pkg::state_t ctl_state;
    logic             ctl_ready;

    dttf_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (ctl_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (ctl_state)
    );

    dttf_datapath #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_code     (chars.char_code),
        .start_of_text (chars.start_of_text),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result)
    );

    assign chars.ready = ctl_ready;

    // error results carry zero value and index
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != dttf_pkg::STATUS_W'(dttf_pkg::STATUS_OK)
        |-> result.value == '0 && result.last_index == '0)
        else $error("error result with nonzero value or index");

    // empty string goes straight to the result stage
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && chars.start_of_text
        && chars.char_code == dttf_pkg::CHAR_NUL
        |=> ctl_state == dttf_pkg::ST_EMIT)
        else $error("empty string did not raise a result");

    // result stage with a free output has the result loaded in the cycle after
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_state == dttf_pkg::ST_EMIT && !(result.valid && !result.ready)
        |=> result.valid && ctl_state == dttf_pkg::ST_DONE)
        else $error("result not loaded into free output");
endmodule
`default_nettype wire

>>> tb/tb_decimal_text_to_fixed_point.sv
// tb_decimal_text_to_fixed_point: self-checking testbench for the decimal text to fixed-point converter
module tb_decimal_text_to_fixed_point;

    localparam int INT_DIGITS    = 5;
    localparam int FRAC_DIGITS   = 4;
    localparam int FRAC_BITS     = 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = FRAC_BITS + 8;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_INT,
        PARSE_FRAC,
        PARSE_DONE
    } parse_phase_t;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        logic signed [dttf_pkg::VALUE_W-1:0] value;
        logic [dttf_pkg::INDEX_W-1:0]        last_index;
        dttf_pkg::status_t                   status;
    } number_result_t;

    logic clk;
    logic rst_n;

    dttf_char_if   chars();
    dttf_result_if result();

    decimal_text_to_fixed_point #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    // parser shadow state
    parse_phase_t                 parse_phase = PARSE_IDLE;
    logic                         is_negative = 1'b0;
    logic [16:0]                  int_value = '0;
    int                           int_count = 0;
    logic [13:0]                  frac_value = '0;
    int                           frac_count = 0;
    logic [dttf_pkg::INDEX_W-1:0] char_pos = '0;

    number_result_t pending_numbers[$];
    int             mismatch_count = 0;
    int             sent_chars = 0;
    int             stall_cycles = 0;
    idle_mode_t     idle_mode = IDLE_SENDER_LIGHT;

    always #10 clk = ~clk;

    function automatic int idle_percent(input bit for_sender);
        case (idle_mode)
            IDLE_SENDER_LIGHT: return for_sender ? 21 : 73;
            IDLE_SENDER_HEAVY: return for_sender ? 73 : 21;
            default:           return 0;
        endcase
    endfunction

    function automatic bit is_digit_char(input logic [dttf_pkg::CHAR_W-1:0] c);
        return c >= dttf_pkg::CHAR_ZERO && c <= dttf_pkg::CHAR_NINE;
    endfunction

    function automatic void close_with_error(input dttf_pkg::status_t code);
        number_result_t r;
        r.value      = '0;
        r.last_index = '0;
        r.status     = code;
        pending_numbers.push_back(r);
        parse_phase = PARSE_DONE;
    endfunction

    function automatic void close_with_value(input logic [dttf_pkg::INDEX_W-1:0] last);
        number_result_t r;
        logic [63:0]    scale;
        logic [63:0]    magnitude;
        int             k;
        scale = 64'd1;
        for (k = 0; k < frac_count; k++)
        begin
            scale = scale * 64'd10;
        end
        // fraction part truncated toward zero before the sign goes on
        magnitude = (64'(int_value) << FRAC_BITS) + ((64'(frac_value) << FRAC_BITS) / scale);
        if (is_negative)
        begin
            magnitude = 64'd0 - magnitude;
        end
        r.value      = magnitude[dttf_pkg::VALUE_W-1:0];
        r.last_index = last;
        r.status     = dttf_pkg::STATUS_OK;
        pending_numbers.push_back(r);
        parse_phase = PARSE_DONE;
    endfunction

    function automatic void take_integer_char(input logic [dttf_pkg::CHAR_W-1:0] c);
        if (is_digit_char(c))
        begin
            if (int_count >= INT_DIGITS)
            begin
                close_with_error(dttf_pkg::STATUS_INT_OVF);
                return;
            end
            int_value = int_value * 17'd10 + 17'(c - dttf_pkg::CHAR_ZERO);
            int_count++;
        end
        else if (int_count == 0)
        begin
            close_with_error(dttf_pkg::STATUS_NO_INT);
        end
        else if (c == dttf_pkg::CHAR_NUL)
        begin
            close_with_value(char_pos - 4'd1);
        end
        else
        begin
            // single separator, fraction digits follow
            parse_phase = PARSE_FRAC;
        end
    endfunction

    function automatic void take_fraction_char(input logic [dttf_pkg::CHAR_W-1:0] c);
        if (is_digit_char(c))
        begin
            if (frac_count >= FRAC_DIGITS)
            begin
                close_with_error(dttf_pkg::STATUS_FRAC_OVF);
                return;
            end
            frac_value = frac_value * 14'd10 + 14'(c - dttf_pkg::CHAR_ZERO);
            frac_count++;
        end
        else if (frac_count == 0)
        begin
            // last digit sits before the separator
            close_with_value(char_pos - 4'd2);
        end
        else
        begin
            close_with_value(char_pos - 4'd1);
        end
    endfunction

    // returns 1 when the character was consumed by the parser
    function automatic bit parse_char(input logic [dttf_pkg::CHAR_W-1:0] c, input logic first);
        if (first)
        begin
            is_negative = 1'b0;
            int_value   = '0;
            int_count   = 0;
            frac_value  = '0;
            frac_count  = 0;
            char_pos    = '0;
            parse_phase = PARSE_INT;
            if (c == dttf_pkg::CHAR_NUL)
            begin
                close_with_error(dttf_pkg::STATUS_EMPTY);
            end
            else if (c == dttf_pkg::CHAR_MINUS)
            begin
                is_negative = 1'b1;
            end
            else if (c != dttf_pkg::CHAR_PLUS)
            begin
                take_integer_char(c);
            end
        end
        else if (parse_phase == PARSE_INT)
        begin
            take_integer_char(c);
        end
        else if (parse_phase == PARSE_FRAC)
        begin
            take_fraction_char(c);
        end
        else
        begin
            return 1'b0;
        end
        if (char_pos < dttf_pkg::POS_MAX)
        begin
            char_pos++;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        number_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_numbers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d index %0d status %0d",
                    result.value, result.last_index, result.status));
            end
            else
            begin
                want = pending_numbers.pop_front();
                if (result.value !== want.value)
                begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                        result.value, want.value));
                end
                if (result.last_index !== want.last_index)
                begin
                    report_mismatch($sformatf("last_index %0d, expected %0d",
                        result.last_index, want.last_index));
                end
                if (result.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                        result.status, want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(0, 99) >= idle_percent(1'b0));
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((chars.valid && chars.ready) || (result.valid && result.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_char(input logic [dttf_pkg::CHAR_W-1:0] code, input logic first);
        while ($urandom_range(0, 99) < idle_percent(1'b1))
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid         <= 1'b1;
        chars.char_code     <= code;
        chars.start_of_text <= first;
        @(posedge clk);
        while (!chars.ready)
        begin
            @(posedge clk);
        end
        void'(parse_char(code, first));
        sent_chars++;
    endtask

    // sends a string, the first transfer flagged as start, plus an optional ending code
    task automatic send_text(input string s, input logic [dttf_pkg::CHAR_W-1:0] ending,
                             input bit with_ending);
        logic first;
        first = 1'b1;
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], first);
            first = 1'b0;
        end
        if (with_ending)
        begin
            send_char(ending, first);
        end
    endtask

    task automatic wait_for_results();
        chars.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_numbers.size() != 0);
    endtask

    function automatic logic [dttf_pkg::CHAR_W-1:0] random_digit(input bit all_nines);
        if (all_nines)
        begin
            return dttf_pkg::CHAR_NINE;
        end
        return dttf_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [dttf_pkg::CHAR_W-1:0] random_non_digit();
        logic [dttf_pkg::CHAR_W-1:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (is_digit_char(c));
        return c;
    endfunction

    function automatic int random_count(input int limit);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return $urandom_range(limit + 1, limit + 2);
        end
        return $urandom_range(1, limit);
    endfunction

    task automatic send_random_number();
        logic [dttf_pkg::CHAR_W-1:0] text[$];
        int                          sign_pick;
        int                          cut;
        bit                          all_nines;
        sign_pick = $urandom_range(0, 2);
        all_nines = ($urandom_range(0, 9) == 0);
        if (sign_pick == 1)
        begin
            text.push_back(dttf_pkg::CHAR_MINUS);
        end
        else if (sign_pick == 2)
        begin
            text.push_back(dttf_pkg::CHAR_PLUS);
        end
        repeat (random_count(INT_DIGITS))
        begin
            text.push_back(random_digit(all_nines));
        end
        if ($urandom_range(0, 4) != 0)
        begin
            text.push_back(random_non_digit());
            repeat (random_count(FRAC_DIGITS))
            begin
                text.push_back(random_digit(all_nines));
            end
        end
        text.push_back($urandom_range(0, 1) ? dttf_pkg::CHAR_NUL : random_non_digit());
        // now and then cut short so the next start drops the number
        if ($urandom_range(0, 19) == 0 && text.size() > 1)
        begin
            cut = $urandom_range(1, text.size() - 1);
            while (text.size() > cut)
            begin
                void'(text.pop_back());
            end
        end
        foreach (text[i])
        begin
            send_char(text[i], i == 0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
        begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_ignored_and_restart();
        send_char("5", 1'b0);
        send_text("8", dttf_pkg::CHAR_NUL, 1'b0);
        send_text("3", dttf_pkg::CHAR_NUL, 1'b1);
        send_char("4", 1'b0);
    endtask

    task automatic test_empty_and_sign();
        send_text("", dttf_pkg::CHAR_NUL, 1'b1);
        send_text("+", "q", 1'b1);
    endtask

    task automatic test_extreme_values();
        send_text("-99999.9999", 8'hFF, 1'b1);
        send_text("0", dttf_pkg::CHAR_NUL, 1'b1);
    endtask

    task automatic test_overflows();
        send_text("123456", dttf_pkg::CHAR_NUL, 1'b0);
        send_text("0.12345", dttf_pkg::CHAR_NUL, 1'b0);
    endtask

    task automatic test_separators();
        send_text("42", dttf_pkg::CHAR_NUL, 1'b1);
        send_text("7,", dttf_pkg::CHAR_NUL, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_numbers(input idle_mode_t mode, input int n_chars);
        int target;
        int pick;
        idle_mode = mode;
        target = sent_chars + n_chars;
        while (sent_chars < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                send_random_number();
            end
            else if (pick < 97)
            begin
                send_noise();
            end
            else
            begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        chars.valid         = 1'b0;
        chars.char_code     = dttf_pkg::CHAR_NUL;
        chars.start_of_text = 1'b0;
        result.ready        = 1'b0;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_and_restart();
        test_empty_and_sign();
        test_extreme_values();
        test_overflows();
        test_separators();
        test_random_numbers(IDLE_SENDER_LIGHT, 320);
        test_random_numbers(IDLE_SENDER_HEAVY, 320);
        test_random_numbers(IDLE_NONE, 320);

        wait_for_results();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/dttf_pkg.sv
sv/dttf_if.sv
sv/dttf_frac_div.sv
sv/dttf_datapath.sv
sv/dttf_controller.sv
sv/decimal_text_to_fixed_point.sv
tb/tb_decimal_text_to_fixed_point.sv
